// ----- design/md5_pkg.sv -----
package md5_pkg;

    // Item operation codes
    localparam logic [1:0] OP_BYTE    = 2'd0;
    localparam logic [1:0] OP_FINISH  = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // Word indices of the two length words in a block
    localparam logic [3:0] LEN_LO_WORD = 4'd14;
    localparam logic [3:0] LEN_HI_WORD = 4'd15;
    localparam logic [3:0] LAST_WORD   = 4'd15;
    localparam logic [5:0] LAST_ROUND  = 6'd63;
    localparam logic [5:0] LAST_FILL   = 6'd63;
    localparam logic [7:0] PAD_BYTE    = 8'h80;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic        status;
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } t_out;

    // Four working or chaining words
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } t_abcd;

    // Block buffer write request
    typedef struct packed {
        logic        we;
        logic [3:0]  addr;
        logic [3:0]  be;
        logic [31:0] data;
    } t_wr;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN_LO,
        ST_LEN_HI,
        ST_PREF,
        ST_RUN,
        ST_ADD,
        ST_EMIT
    } t_state;

    // What follows the compression now running
    typedef enum logic [1:0] {
        PH_MSG,
        PH_SPLIT,
        PH_LAST
    } t_phase;

    localparam t_abcd CHAIN_INIT = '{
        a: 32'h67452301,
        b: 32'hefcdab89,
        c: 32'h98badcfe,
        d: 32'h10325476
    };

    // Additive constant of each round
    function automatic logic [31:0] round_k(input logic [5:0] rnd);
        logic [31:0] k;
        case (rnd)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // Rotate amount: four per quarter, picked by the low two round bits
    function automatic logic [4:0] round_s(input logic [5:0] rnd);
        logic [4:0] s;
        case ({rnd[5:4], rnd[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // Message word used by a round (mod 16 arithmetic on 4 bits)
    function automatic logic [3:0] msg_sel(input logic [5:0] rnd);
        logic [3:0] i;
        logic [3:0] g;
        i = rnd[3:0];
        case (rnd[5:4])
            2'd0:    g = i;
            2'd1:    g = 4'd5 * i + 4'd1;
            2'd2:    g = 4'd3 * i + 4'd5;
            2'd3:    g = 4'd7 * i;
            default: g = i;
        endcase
        return g;
    endfunction

endpackage

// ----- design/md5_buf.sv -----
module md5_buf (
    input  logic              i_clk,
    input  md5_pkg::t_wr      i_wr,
    input  logic [3:0]        i_raddr,
    output logic [31:0]       o_rdata
);
    import md5_pkg::*;

    // 16 little-endian words, byte lanes written separately
    logic [3:0][7:0] mem [16];

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 4; j++) begin
            if (i_wr.we && i_wr.be[j]) begin
                mem[i_wr.addr][j] <= i_wr.data[8*j +: 8];
            end
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

// ----- design/md5_round.sv -----
module md5_round (
    input  md5_pkg::t_abcd    i_st,
    input  logic [31:0]       i_m,
    input  logic [5:0]        i_rnd,
    output md5_pkg::t_abcd    o_st
);
    import md5_pkg::*;

    logic [31:0] f;
    logic [31:0] sum;
    logic [63:0] dbl;

    // Round function by quarter
    always_comb begin
        case (i_rnd[5:4])
            2'd0:    f = (i_st.b & i_st.c) | (~i_st.b & i_st.d);
            2'd1:    f = (i_st.d & i_st.b) | (~i_st.d & i_st.c);
            2'd2:    f = i_st.b ^ i_st.c ^ i_st.d;
            2'd3:    f = i_st.c ^ (i_st.b | ~i_st.d);
            default: f = '0;
        endcase
    end

    // Sum, rotate left, add b, shuffle words
    assign sum    = i_st.a + f + round_k(i_rnd) + i_m;
    assign dbl    = {sum, sum} << round_s(i_rnd);
    assign o_st.a = i_st.d;
    assign o_st.b = i_st.b + dbl[63:32];
    assign o_st.c = i_st.b;
    assign o_st.d = i_st.c;

endmodule

// ----- design/md5_message_digest.sv -----
// Streaming MD5 hasher. Send one word per message byte (op 0), then a finish
// word (op 1), which returns the digest as four 32-bit words a, b, c, d with
// the first digest byte in the low byte of each; last_word marks word d.
// A restart word (op 2) starts a new hash; a byte or finish word after
// finish returns one refusal word (status 1) until the restart. Each message
// byte is written into the block buffer; the 64th byte of a block also
// starts the compression: a prefetch state, 64 rounds at one round per cycle
// through a single round unit reading one buffer word per cycle, and a fold
// into the chaining words. Finish pads word by word to the end of the block,
// writes the length and compresses; for a final fill of 56 bytes or more it
// first pads and compresses that block, then sweeps a zero block, writes the
// length and compresses again. The four digest words then leave at up to one
// per cycle. The input is stalled while any of this runs or while a result
// word waits in the output register.
module md5_message_digest (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  md5_pkg::t_in    i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output md5_pkg::t_out   o_data
);
    import md5_pkg::*;

    t_state      r_state, n_state;
    t_phase      r_phase, n_phase;
    logic [5:0]  r_rnd, n_rnd;
    logic [3:0]  r_wa, n_wa;
    logic        r_first, n_first;
    logic [5:0]  r_fill, n_fill;
    logic [31:0] r_cnt, n_cnt;
    logic        r_fin, n_fin;
    t_abcd       r_chain, n_chain;
    t_abcd       r_work, n_work;
    logic [1:0]  r_idx, n_idx;
    t_out        r_out, n_out;
    logic        r_out_valid, n_out_valid;

    t_wr         wr;
    logic [3:0]  rd_addr;
    logic [31:0] rd_data;
    t_abcd       rnd_out;
    logic        in_acc;
    logic        out_take;
    logic [31:0] sel_word;

    md5_buf u_buf (
        .i_clk   (i_clk),
        .i_wr    (wr),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    md5_round u_round (
        .i_st  (r_work),
        .i_m   (rd_data),
        .i_rnd (r_rnd),
        .o_st  (rnd_out)
    );

    assign o_stall  = (r_state != ST_IDLE) || r_out_valid;
    assign in_acc   = i_valid && !o_stall;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;
    assign out_take = r_out_valid && !i_stall;

    // Digest word picked for output
    always_comb begin
        case (r_idx)
            2'd0:    sel_word = r_chain.a;
            2'd1:    sel_word = r_chain.b;
            2'd2:    sel_word = r_chain.c;
            2'd3:    sel_word = r_chain.d;
            default: sel_word = r_chain.a;
        endcase
    end

    // Sequencer: next state, buffer port, output register
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_rnd       = r_rnd;
        n_wa        = r_wa;
        n_first     = r_first;
        n_fill      = r_fill;
        n_cnt       = r_cnt;
        n_fin       = r_fin;
        n_chain     = r_chain;
        n_work      = r_work;
        n_idx       = r_idx;
        n_out       = r_out;
        n_out_valid = r_out_valid && !out_take;
        wr          = '0;
        rd_addr     = '0;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (i_data.op)
                        OP_BYTE: begin
                            if (r_fin) begin
                                n_out       = '{status: 1'b1, digest_word: '0,
                                                word_index: '0, last_word: 1'b1};
                                n_out_valid = 1'b1;
                            end else begin
                                wr.we   = 1'b1;
                                wr.addr = r_fill[5:2];
                                wr.be   = 4'b0001 << r_fill[1:0];
                                wr.data = {4{i_data.data_byte}};
                                n_cnt   = r_cnt + 32'd1;
                                n_fill  = r_fill + 6'd1;
                                if (r_fill == LAST_FILL) begin
                                    n_state = ST_PREF;
                                    n_phase = PH_MSG;
                                end
                            end
                        end
                        OP_FINISH: begin
                            if (r_fin) begin
                                n_out       = '{status: 1'b1, digest_word: '0,
                                                word_index: '0, last_word: 1'b1};
                                n_out_valid = 1'b1;
                            end else begin
                                n_state = ST_PAD;
                                n_wa    = r_fill[5:2];
                                n_first = 1'b1;
                                n_phase = (r_fill[5:3] == 3'b111) ? PH_SPLIT : PH_LAST;
                            end
                        end
                        OP_RESTART: begin
                            n_chain = CHAIN_INIT;
                            n_fill  = '0;
                            n_cnt   = '0;
                            n_fin   = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Pad marker in the partial word (none on the split zero sweep), zeros to the end of the block
            ST_PAD: begin
                wr.we   = 1'b1;
                wr.addr = r_wa;
                if (r_first) begin
                    for (int j = 0; j < 4; j++) begin
                        wr.be[j]         = (2'(j) >= r_fill[1:0]);
                        wr.data[8*j +: 8] = (2'(j) == r_fill[1:0]) ? PAD_BYTE : 8'h00;
                    end
                end else begin
                    wr.be = 4'hf;
                end
                n_first = 1'b0;
                n_wa    = r_wa + 4'd1;
                if (r_wa == LAST_WORD) begin
                    n_state = (r_phase == PH_SPLIT) ? ST_PREF : ST_LEN_LO;
                end
            end

            ST_LEN_LO: begin
                wr.we   = 1'b1;
                wr.addr = LEN_LO_WORD;
                wr.be   = 4'hf;
                wr.data = {r_cnt[28:0], 3'b000};
                n_state = ST_LEN_HI;
            end

            ST_LEN_HI: begin
                wr.we   = 1'b1;
                wr.addr = LEN_HI_WORD;
                wr.be   = 4'hf;
                wr.data = {29'd0, r_cnt[31:29]};
                n_state = ST_PREF;
            end

            // Fetch the first message word, load working words
            ST_PREF: begin
                rd_addr = msg_sel(6'd0);
                n_work  = r_chain;
                n_rnd   = '0;
                n_state = ST_RUN;
            end

            // One round per cycle, next round's word fetched alongside
            ST_RUN: begin
                rd_addr = msg_sel(r_rnd + 6'd1);
                n_work  = rnd_out;
                n_rnd   = r_rnd + 6'd1;
                if (r_rnd == LAST_ROUND) begin
                    n_state = ST_ADD;
                end
            end

            ST_ADD: begin
                n_chain.a = r_chain.a + r_work.a;
                n_chain.b = r_chain.b + r_work.b;
                n_chain.c = r_chain.c + r_work.c;
                n_chain.d = r_chain.d + r_work.d;
                case (r_phase)
                    PH_MSG: begin
                        n_state = ST_IDLE;
                    end
                    PH_SPLIT: begin
                        n_state = ST_PAD;
                        n_wa    = '0;
                        n_first = 1'b0;
                        n_phase = PH_LAST;
                    end
                    PH_LAST: begin
                        n_state = ST_EMIT;
                        n_idx   = '0;
                        n_fin   = 1'b1;
                        n_fill  = '0;
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end

            // Four digest words through the output register
            ST_EMIT: begin
                if (!r_out_valid || out_take) begin
                    n_out       = '{status: 1'b0, digest_word: sel_word,
                                    word_index: r_idx, last_word: (r_idx == 2'd3)};
                    n_out_valid = 1'b1;
                    n_idx       = r_idx + 2'd1;
                    if (r_idx == 2'd3) begin
                        n_state = ST_IDLE;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_MSG;
            r_fill      <= '0;
            r_cnt       <= '0;
            r_fin       <= 1'b0;
            r_chain     <= CHAIN_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_fill      <= n_fill;
            r_cnt       <= n_cnt;
            r_fin       <= n_fin;
            r_chain     <= n_chain;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath and counters
    always_ff @(posedge i_clk) begin
        r_rnd   <= n_rnd;
        r_wa    <= n_wa;
        r_first <= n_first;
        r_work  <= n_work;
        r_idx   <= n_idx;
        r_out   <= n_out;
    end

endmodule

// ----- test/tb_md5_message_digest.sv -----
module tb_md5_message_digest;

    // Op code three has no meaning; the block must ignore it
    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam logic [7:0] PAD_MARK     = 8'h80;
    localparam int         ITEM_TARGET  = 280;
    localparam int         IDLE_LIMIT   = 4000;
    localparam int         DRAIN_CYCLES = 250;

    // Per-round additive constants and rotate amounts of MD5
    localparam logic [31:0] SINE_ADD [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    localparam int ROT_AMT [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    // Tracks the hash state and holds the digest words still due
    class digest_tracker;
        md5_pkg::t_out due_words [$];
        logic [31:0]   chain [4];
        logic [7:0]    blk [64];
        logic [5:0]    fill;
        logic [31:0]   msg_len;
        bit            done;
        int            errors;
        int            words_checked;
        int            digests;
        int            refusals;
        int            blocks;
        int            split_pads;

        function new();
            restart_hash();
        endfunction

        function void restart_hash();
            chain[0] = 32'h67452301;
            chain[1] = 32'hefcdab89;
            chain[2] = 32'h98badcfe;
            chain[3] = 32'h10325476;
            foreach (blk[k]) blk[k] = 8'h00;
            fill    = '0;
            msg_len = '0;
            done    = 1'b0;
        endfunction

        static function logic [31:0] rotl(logic [31:0] x, int n);
            logic [63:0] w;
            w = {x, x} << n;
            return w[63:32];
        endfunction

        // One 64-round compression of the block buffer into the chain
        function void compress();
            logic [31:0] m [16];
            logic [31:0] a, b, c, d, f, t;
            int          g;
            for (int k = 0; k < 16; k++)
                m[k] = {blk[4*k+3], blk[4*k+2], blk[4*k+1], blk[4*k]};
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            for (int r = 0; r < 64; r++) begin
                case (r / 16)
                    0: begin
                        f = (b & c) | (~b & d);
                        g = r;
                    end
                    1: begin
                        f = (d & b) | (~d & c);
                        g = (5 * r + 1) % 16;
                    end
                    2: begin
                        f = b ^ c ^ d;
                        g = (3 * r + 5) % 16;
                    end
                    default: begin
                        f = c ^ (b | ~d);
                        g = (7 * r) % 16;
                    end
                endcase
                t = d;
                d = c;
                c = b;
                b = b + rotl(a + f + SINE_ADD[r] + m[g], ROT_AMT[(r / 16) * 4 + r % 4]);
                a = t;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
            blocks++;
        endfunction

        function void push_word(bit st, logic [31:0] dw, logic [1:0] idx, bit last);
            md5_pkg::t_out e;
            e.status      = st;
            e.digest_word = dw;
            e.word_index  = idx;
            e.last_word   = last;
            due_words.push_back(e);
        endfunction

        // Padding, length field and final compression, then the digest
        function void pad_and_emit();
            logic [31:0] bits_lo;
            logic [31:0] bits_hi;
            blk[fill] = PAD_MARK;
            for (int k = int'(fill) + 1; k < 64; k++) blk[k] = 8'h00;
            // No room for the length: an extra block of zeros follows
            if (fill >= 6'd56) begin
                compress();
                foreach (blk[k]) blk[k] = 8'h00;
                split_pads++;
            end
            bits_lo = msg_len << 3;
            bits_hi = msg_len >> 29;
            for (int k = 0; k < 4; k++) begin
                blk[56 + k] = bits_lo[8*k +: 8];
                blk[60 + k] = bits_hi[8*k +: 8];
            end
            compress();
            fill = '0;
            done = 1'b1;
            digests++;
            for (int k = 0; k < 4; k++) push_word(1'b0, chain[k], 2'(k), k == 3);
        endfunction

        // Accepted input word
        function void take_word(md5_pkg::t_in w);
            if (w.op == md5_pkg::OP_RESTART) begin
                restart_hash();
            end else if (w.op == OP_UNUSED) begin
                // ignored
            end else if (done) begin
                push_word(1'b1, 32'h0, 2'd0, 1'b1);
                refusals++;
            end else if (w.op == md5_pkg::OP_BYTE) begin
                blk[fill] = w.data_byte;
                msg_len++;
                fill++;
                if (fill == 6'd0) compress();
            end else begin
                pad_and_emit();
            end
        endfunction

        task flag_mismatch(string what);
            errors++;
            $display("MISMATCH: %s", what);
        endtask

        // Accepted result word against the oldest one due
        task check_word(md5_pkg::t_out got);
            md5_pkg::t_out want;
            words_checked++;
            if (due_words.size() == 0) begin
                flag_mismatch($sformatf("result %0d arrived with nothing due (%h)",
                                        words_checked, got));
                return;
            end
            want = due_words.pop_front();
            if (got.status != want.status)
                flag_mismatch($sformatf("result %0d status got %0d want %0d",
                                        words_checked, got.status, want.status));
            if (got.digest_word != want.digest_word)
                flag_mismatch($sformatf("result %0d digest_word got %h want %h",
                                        words_checked, got.digest_word, want.digest_word));
            if (got.word_index != want.word_index)
                flag_mismatch($sformatf("result %0d word_index got %0d want %0d",
                                        words_checked, got.word_index, want.word_index));
            if (got.last_word != want.last_word)
                flag_mismatch($sformatf("result %0d last_word got %0d want %0d",
                                        words_checked, got.last_word, want.last_word));
        endtask

        task close_out();
            if (due_words.size() != 0)
                flag_mismatch($sformatf("%0d result words never arrived", due_words.size()));
        endtask
    endclass

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          i_stall = 1'b0;
    md5_pkg::t_in  i_data  = '0;
    logic          o_stall;
    logic          o_valid;
    md5_pkg::t_out o_data;

    digest_tracker tracker = new();
    int            sent_items  = 0;
    int            burst_left  = 0;
    int            idle_cycles = 0;
    int            stall_mode  = 0;
    int            mode_left   = 0;
    int            stall_phase = 0;
    int            pick;
    int            len;

    md5_message_digest u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver back-pressure: modes of free flow, light, heavy and periodic stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 150);
            end
            mode_left--;
            stall_phase = (stall_phase + 1) % 5;
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                2: i_stall <= ($urandom_range(0, 3) != 0);
                default: i_stall <= (stall_phase != 0);
            endcase
        end
    end

    // Handshake monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) tracker.take_word(i_data);
            if (o_valid && !i_stall) tracker.check_word(o_data);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Watchdog: no word moved for %0d cycles", IDLE_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Offer one word, with random gaps between bursts
    task automatic send_word(input logic [1:0] op, input logic [7:0] d);
        md5_pkg::t_in w;
        w.op        = op;
        w.data_byte = d;
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_data  <= w;
        do @(posedge i_clk); while (o_stall);
        if (op != OP_UNUSED) sent_items++;
    endtask

    // One message: optional restart, bytes with stray noise, optional finish
    task automatic hash_message(input int n, input bit fresh, input bit finish_it);
        if (fresh) send_word(md5_pkg::OP_RESTART, 8'($urandom));
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 29) == 0) send_word(OP_UNUSED, 8'($urandom));
            send_word(md5_pkg::OP_BYTE, 8'($urandom));
        end
        if (finish_it) begin
            send_word(md5_pkg::OP_FINISH, 8'($urandom));
            // a late word after the digest is refused
            if ($urandom_range(0, 4) == 0)
                send_word($urandom_range(0, 1) ? md5_pkg::OP_FINISH : md5_pkg::OP_BYTE,
                          8'($urandom));
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty message, refusals while finished, ignored op code
        send_word(md5_pkg::OP_RESTART, 8'h00);
        send_word(md5_pkg::OP_FINISH, 8'hff);
        send_word(md5_pkg::OP_BYTE, 8'h5a);
        send_word(md5_pkg::OP_FINISH, 8'h00);
        send_word(OP_UNUSED, 8'hff);
        // Short message with extreme byte values and noise inside it
        send_word(md5_pkg::OP_RESTART, 8'hff);
        send_word(md5_pkg::OP_BYTE, 8'h00);
        send_word(md5_pkg::OP_BYTE, 8'hff);
        send_word(OP_UNUSED, 8'h00);
        send_word(md5_pkg::OP_BYTE, 8'h80);
        send_word(md5_pkg::OP_FINISH, 8'h00);
        // Restart part way through a message
        send_word(md5_pkg::OP_RESTART, 8'h00);
        send_word(md5_pkg::OP_BYTE, 8'h61);
        send_word(md5_pkg::OP_RESTART, 8'h00);
        send_word(md5_pkg::OP_FINISH, 8'h00);
        send_word(md5_pkg::OP_RESTART, 8'h00);

        // Random messages: mostly short, some near or across block boundaries
        while (sent_items < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) len = $urandom_range(0, 8);
            else if (pick < 85) len = $urandom_range(50, 66);
            else len = $urandom_range(64, 130);
            hash_message(len, $urandom_range(0, 9) != 0, $urandom_range(0, 11) != 0);
        end
        i_valid <= 1'b0;

        while (tracker.due_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        tracker.close_out();

        $display("Sent %0d words: %0d digests, %0d refusals, %0d block compressions, %0d %s",
                 sent_items, tracker.digests, tracker.refusals, tracker.blocks,
                 tracker.split_pads, "finishes needing an extra padding block");
        $display("Checked %0d result words, %0d mismatches",
                 tracker.words_checked, tracker.errors);
        if (tracker.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- md5_message_digest.f -----
design/md5_pkg.sv
design/md5_buf.sv
design/md5_round.sv
design/md5_message_digest.sv
test/tb_md5_message_digest.sv
